### rtl/sv39m_pkg.sv
// ----------------------------------------------------------------------------
// sv39m_pkg
// Shared types and constants of the Sv39 page table mapper: pool geometry,
// page table entry layout, request and result payloads, unit interfaces.
// ----------------------------------------------------------------------------
package sv39m_pkg;

  // Pool geometry
  localparam int TABLE_SLOTS       = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int VPN_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int SLOT_W            = $clog2(TABLE_SLOTS);
  localparam int ADDR_W            = SLOT_W + VPN_W;
  localparam int POOL_ENTRIES      = TABLE_SLOTS * ENTRIES_PER_TABLE;

  // Entry layout
  localparam int PTE_W     = 64;
  localparam int PPN_W     = 44;
  localparam int PPN_LSB   = 10;
  localparam int PAGE_BITS = 12;

  // Request and result field widths
  localparam int VA_W   = 39;
  localparam int PA_W   = 56;
  localparam int PERM_W = 3;
  localparam int IDX_W  = 13;
  localparam int USED_W = 5;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_LSB = 3;
  localparam logic [CFG_ADDR_W-REG_IDX_LSB-1:0] REG_POOL_BASE = '0;
  localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'd524295;

  typedef enum logic {
    ACT_MAP  = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [VA_W-1:0]     virtual_address;
    logic [PA_W-1:0]     physical_address;
    logic [PERM_W-1:0]   permissions;
    logic [IDX_W-1:0]    entry_index;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [PTE_W-1:0]    leaf_entry;
    logic [PTE_W-1:0]    read_data;
    logic [USED_W-1:0]   tables_used;
  } out_item_t;

  // Page number unit
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [PPN_W-1:0]    a;
    logic [PPN_W-1:0]    b;
  } alu_req_t;

  typedef struct packed {
    logic [PPN_W-1:0]    value;
    logic                in_pool;
  } alu_res_t;

  // Pool memory port
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [PTE_W-1:0]    wdata;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

endpackage

### rtl/sv39m_ppn_alu.sv
// ----------------------------------------------------------------------------
// sv39m_ppn_alu
// Shared page number adder: forms the page number of a fresh slot, or the
// slot offset of a stored pointer, and flags whether that lands in the pool.
// ----------------------------------------------------------------------------
module sv39m_ppn_alu (
  input  sv39m_pkg::alu_req_t req,
  output sv39m_pkg::alu_res_t res
);
  import sv39m_pkg::*;

  // 44-bit add or subtract, wrapping
  always_comb begin
    unique case (req.op)
      ALU_ADD: res.value = req.a + req.b;
      ALU_SUB: res.value = req.a - req.b;
      default: res.value = '0;
    endcase
    res.in_pool = (res.value < PPN_W'(TABLE_SLOTS));
  end

endmodule

### rtl/sv39m_pool_mem.sv
// ----------------------------------------------------------------------------
// sv39m_pool_mem
// Page table pool storage: one write and one registered read per cycle,
// a read of the address being written returns the new data.
// ----------------------------------------------------------------------------
module sv39m_pool_mem (
  input  logic                              clk,
  input  sv39m_pkg::mem_req_t               req,
  output logic [sv39m_pkg::PTE_W-1:0]       rdata
);
  import sv39m_pkg::*;

  logic [PTE_W-1:0] mem [POOL_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read, new data on a collision
  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr)) begin
      rdata <= req.wdata;
    end else begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### rtl/sv39_page_table_mapper.sv
// ----------------------------------------------------------------------------
// sv39_page_table_mapper
// Sv39 page table insertion over a fixed pool of tables, with entry readback.
// ----------------------------------------------------------------------------
// Map request: the walk reads the root level, then the second level, writes
// the leaf and loads the result; a refused walk stops at the root or second
// level. Read request: one entry is read. No request is accepted until the
// result is loaded. The walk is paced by the single pool memory port, one
// table level a cycle. After reset a clearing pass zeroes all POOL_ENTRIES
// (8192) entries, one entry a cycle; no request is accepted meanwhile, config is.
// ----------------------------------------------------------------------------
module sv39_page_table_mapper (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  sv39m_pkg::in_item_t                   in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output sv39m_pkg::out_item_t                  out_data,
  // configuration port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [sv39m_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [sv39m_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [sv39m_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                  cfg_pready
);
  import sv39m_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_WALK  = 6'b001000,
    S_LEAF  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic [PPN_W-1:0]    base_r;
  logic                lvl_r, lvl_nxt;
  logic                out_valid_r, out_valid_nxt;
  in_item_t            item_r;
  logic [ADDR_W-1:0]   pos_r;
  logic                oob_r;
  logic                status_r, status_nxt;
  logic [PTE_W-1:0]    leaf_r, leaf_nxt;
  logic [PTE_W-1:0]    rd_r, rd_nxt;
  out_item_t           out_item_r;

  logic                accept;
  logic                out_load;
  logic                cfg_wr;
  logic [PTE_W-1:0]    rdata;
  mem_req_t            mem_req;
  alu_req_t            alu_req;
  alu_res_t            alu_res;
  logic                ent_valid;
  logic                exhausted;
  logic                walk_fail;
  logic [SLOT_W-1:0]   slot_next;
  logic [SLOT_W-1:0]   cnt_inc;
  logic [VPN_W-1:0]    vpn_next;
  logic [PTE_W-1:0]    leaf_bits;

  // Units
  sv39m_pool_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  sv39m_ppn_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Handshakes
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_ADDR_W-1:REG_IDX_LSB] == REG_POOL_BASE);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:REG_IDX_LSB] == REG_POOL_BASE) ?
                      CFG_DATA_W'(base_r) : '0;

  // Walk step terms
  assign ent_valid = rdata[0];
  assign cnt_inc   = cnt_r + 1'b1;
  assign exhausted = ((SLOT_W + 1)'(cnt_r) + 1'b1) >= (SLOT_W + 1)'(TABLE_SLOTS);
  assign walk_fail = ent_valid ? !alu_res.in_pool : exhausted;
  assign slot_next = ent_valid ? alu_res.value[SLOT_W-1:0] : cnt_inc;
  assign vpn_next  = lvl_r ? item_r.virtual_address[29:21]
                           : item_r.virtual_address[20:12];
  assign leaf_bits = {10'b0, item_r.physical_address[PA_W-1:PAGE_BITS], 6'b0,
                      item_r.permissions, 1'b1};

  // Shared unit: offset of a stored pointer, or page number of a fresh slot
  always_comb begin
    if (ent_valid) begin
      alu_req.op = ALU_SUB;
      alu_req.a  = rdata[PPN_LSB +: PPN_W];
      alu_req.b  = base_r;
    end else begin
      alu_req.op = ALU_ADD;
      alu_req.a  = base_r;
      alu_req.b  = PPN_W'(cnt_inc);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cnt_nxt       = cnt_r;
    lvl_nxt       = lvl_r;
    status_nxt    = status_r;
    leaf_nxt      = leaf_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    mem_req       = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        mem_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(POOL_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          status_nxt = 1'b0;
          leaf_nxt   = '0;
          rd_nxt     = '0;
          lvl_nxt    = 1'b1;
          if (in_data.action == ACT_READ) begin
            mem_req.raddr = ADDR_W'(in_data.entry_index);
            state_nxt     = S_READ;
          end else begin
            mem_req.raddr = {SLOT_W'(0), in_data.virtual_address[38:30]};
            state_nxt     = S_WALK;
          end
        end
      end
      S_READ: begin
        rd_nxt    = oob_r ? '0 : rdata;
        state_nxt = S_FIN;
      end
      S_WALK: begin
        if (walk_fail) begin
          status_nxt = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          // allocate on an empty pointer
          if (!ent_valid) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_r;
            mem_req.wdata = rdata | {10'b0, alu_res.value, 10'b0} | PTE_W'(1);
            cnt_nxt       = cnt_inc;
          end
          mem_req.raddr = {slot_next, vpn_next};
          lvl_nxt       = 1'b0;
          state_nxt     = lvl_r ? S_WALK : S_LEAF;
        end
      end
      S_LEAF: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = rdata | leaf_bits;
        leaf_nxt      = rdata | leaf_bits;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= SLOT_W'(1);
      lvl_r       <= 1'b1;
      out_valid_r <= 1'b0;
      base_r      <= POOL_BASE_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        base_r <= cfg_pwdata[PPN_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    leaf_r   <= leaf_nxt;
    rd_r     <= rd_nxt;
    if (accept) begin
      item_r <= in_data;
      oob_r  <= (32'(in_data.entry_index) >= 32'(POOL_ENTRIES));
    end
    if (accept || (state_r == S_WALK)) begin
      pos_r <= mem_req.raddr;
    end
    if (out_load) begin
      out_item_r.status      <= status_r;
      out_item_r.leaf_entry  <= leaf_r;
      out_item_r.read_data   <= rd_r;
      out_item_r.tables_used <= USED_W'(cnt_r);
    end
  end

`ifndef SYNTHESIS
  // allocation counter only ever steps up by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |-> cnt_r == SLOT_W'($past(cnt_r) + 1'b1))
    else $error("allocation counter jumped");

  // pool is written only by the clearing pass or a walk
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_CLEAR) || (state_r == S_WALK) || (state_r == S_LEAF))
    else $error("pool write outside a walk");

  // a result appears only out of the finishing step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish");

  // no request taken before the clearing pass is done
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready && !out_load)
    else $error("request accepted during pool clear");
`endif

endmodule
